### sv/text_console_char_writer_top_macros.svh
// assertion macros for the text console character writer
// expects clk and arst_n in the scope where a macro is used

`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never be seen
`define TCW_ASSERT_NEVER(label, cond, msg) \
	`TCW_ASSERT_IMPL(label, 1'b1, !(cond), msg)

`endif

### sv/tcw_pkg.sv
// shared types and constants for the text console character writer
// no dependencies

package tcw_pkg;

	localparam int DEF_COLUMNS  = 80;
	localparam int DEF_ROWS     = 25;
	localparam int DEF_TAB_STOP = 8;

	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] TAB_CHAR     = 8'h09;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] RESET_COLOR  = 8'h07;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// port-level action codes
	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// classified command, decided by the front end
	typedef enum logic [2:0] {
		OP_PRINT   = 3'd0,
		OP_TAB     = 3'd1,
		OP_NEWLINE = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_READ    = 3'd4,
		OP_NONE    = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
		logic       in_range;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

### sv/tcw_front.sv
// front end: takes input beats and classifies them into commands
// depends on tcw_pkg

module tcw_front #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic          start,
	input  logic [1:0]    action,
	input  logic [7:0]    char_code,
	input  logic [4:0]    read_row,
	input  logic [6:0]    read_col,
	input  logic          q_full,
	input  logic          init_busy,
	output logic          busy,
	output logic          push,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	assign busy = q_full | init_busy;
	assign push = start & ~busy;

	always_comb begin
		cmd.ch       = char_code;
		cmd.row      = read_row;
		cmd.col      = read_col;
		cmd.in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
		case (action_t'(action))
			ACT_PUT: begin
				if (char_code == TAB_CHAR) begin
					cmd.op = OP_TAB;
				end else if (char_code == NEWLINE_CHAR) begin
					cmd.op = OP_NEWLINE;
				end else begin
					cmd.op = OP_PRINT;
				end
			end
			ACT_CLEAR: cmd.op = OP_CLEAR;
			ACT_READ:  cmd.op = OP_READ;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

### sv/tcw_queue.sv
// short command queue between front end and back end
// depends on tcw_pkg

module tcw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcw_pkg::cmd_t  cmd,
	input  logic           pop,
	output tcw_pkg::head_t head,
	output logic           full
);
	import tcw_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

### sv/tcw_back.sv
// back end: cursor, cell memory, sweeps for reset, clear and scroll, result beat
// depends on tcw_pkg

module tcw_back #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tcw_pkg::head_t head,
	input  logic [7:0]     text_color,
	output logic           pop,
	output logic           init_busy,
	output logic           done,
	output logic [15:0]    cell_value,
	output logic [6:0]     cursor_col,
	output logic [4:0]     cursor_row,
	output logic           scrolled
);
	import tcw_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int STOP_W = COL_W + 1;

	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW_LEN  = ADDR_W'(COLUMNS);
	localparam logic [PH_W-1:0]   PH_LAST  = PH_W'(TAB_STOP - 1);
	localparam logic [PH_W-1:0]   PH_ONE   = PH_W'(1 % TAB_STOP);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_SWEEP  = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		SW_INIT   = 2'd0,
		SW_CLEAR  = 2'd1,
		SW_SCROLL = 2'd2
	} sweep_t;

	state_t            state_q, state_d;
	sweep_t            kind_q, kind_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [PH_W-1:0]   ph_q, ph_d;
	logic              pend_q, pend_d;
	logic [7:0]        pend_ch_q, pend_ch_d;
	logic              init_q, init_d;

	logic              wv_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic              wblank_s1;

	logic [15:0]       mem [CELLS];
	logic [15:0]       rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [15:0]       wr_data;

	logic              emit;
	logic [15:0]       emit_cell;
	logic              emit_scr;

	logic              done_q;
	logic [15:0]       cell_q;
	logic [6:0]        ocol_q;
	logic [4:0]        orow_q;
	logic              scr_q;

	logic [ADDR_W-1:0] base_addr;
	logic [STOP_W-1:0] stop;
	logic              tab_wrap;
	logic              at_end;
	logic [PH_W-1:0]   ph_inc;
	logic [15:0]       blank_cell;
	logic              copy_phase;

	assign base_addr  = ADDR_W'(ADDR_W'(row_q) * ROW_LEN);
	assign stop       = STOP_W'(STOP_W'(col_q) - STOP_W'(ph_q) + STOP_W'(TAB_STOP));
	assign tab_wrap   = (stop >= STOP_W'(COLUMNS));
	assign at_end     = (col_q >= COL_W'(COLUMNS));
	assign ph_inc     = (ph_q == PH_LAST) ? '0 : PH_W'(ph_q + 1'b1);
	assign blank_cell = {(kind_q == SW_INIT) ? RESET_COLOR : text_color, BLANK_CHAR};
	assign copy_phase = (kind_q == SW_SCROLL) && (idx_q < COPY_END);

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		idx_d     = idx_q;
		col_d     = col_q;
		row_d     = row_q;
		ph_d      = ph_q;
		pend_d    = pend_q;
		pend_ch_d = pend_ch_q;
		init_d    = init_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_cell = '0;
		emit_scr  = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = waddr_s1;
		wr_data   = wblank_s1 ? blank_cell : rd_data_q;

		if (wv_s1) begin
			wr_en = 1'b1;
		end

		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					case (head.cmd.op)
						OP_PRINT: begin
							if (at_end && (row_q == LAST_ROW)) begin
								col_d     = '0;
								ph_d      = '0;
								pend_d    = 1'b1;
								pend_ch_d = head.cmd.ch;
								kind_d    = SW_SCROLL;
								idx_d     = '0;
								state_d   = ST_SWEEP;
							end else if (at_end) begin
								wr_en   = 1'b1;
								wr_addr = ADDR_W'(base_addr + ROW_LEN);
								wr_data = {text_color, head.cmd.ch};
								row_d   = ROW_W'(row_q + 1'b1);
								col_d   = COL_W'(1);
								ph_d    = PH_ONE;
								emit    = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_addr = ADDR_W'(base_addr + ADDR_W'(col_q));
								wr_data = {text_color, head.cmd.ch};
								col_d   = COL_W'(col_q + 1'b1);
								ph_d    = ph_inc;
								emit    = 1'b1;
							end
						end
						OP_TAB, OP_NEWLINE: begin
							if ((head.cmd.op == OP_TAB) && !tab_wrap) begin
								col_d = COL_W'(stop);
								ph_d  = '0;
								emit  = 1'b1;
							end else begin
								col_d = '0;
								ph_d  = '0;
								if (row_q == LAST_ROW) begin
									pend_d  = 1'b0;
									kind_d  = SW_SCROLL;
									idx_d   = '0;
									state_d = ST_SWEEP;
								end else begin
									row_d = ROW_W'(row_q + 1'b1);
									emit  = 1'b1;
								end
							end
						end
						OP_CLEAR: begin
							pend_d  = 1'b0;
							kind_d  = SW_CLEAR;
							idx_d   = '0;
							state_d = ST_SWEEP;
						end
						OP_READ: begin
							if (head.cmd.in_range) begin
								rd_addr = ADDR_W'(ADDR_W'(head.cmd.row) * ROW_LEN
									+ ADDR_W'(head.cmd.col));
								state_d = ST_READ;
							end else begin
								emit = 1'b1;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				emit      = 1'b1;
				emit_cell = rd_data_q;
				state_d   = ST_IDLE;
			end
			ST_SWEEP: begin
				// read ahead one row, write lands in the following cycle from stage 1
				if (copy_phase) begin
					rd_addr = ADDR_W'(idx_q + ROW_LEN);
				end
				idx_d = ADDR_W'(idx_q + 1'b1);
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
				case (kind_q)
					SW_INIT: begin
						init_d = 1'b0;
					end
					SW_CLEAR: begin
						col_d = '0;
						row_d = '0;
						ph_d  = '0;
						emit  = 1'b1;
					end
					default: begin
						emit     = 1'b1;
						emit_scr = 1'b1;
						if (pend_q) begin
							wr_en   = 1'b1;
							wr_addr = COPY_END;
							wr_data = {text_color, pend_ch_q};
							col_d   = COL_W'(1);
							ph_d    = PH_ONE;
						end
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			kind_q  <= SW_INIT;
			idx_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			ph_q    <= '0;
			pend_q  <= 1'b0;
			init_q  <= 1'b1;
			wv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			idx_q   <= idx_d;
			col_q   <= col_d;
			row_q   <= row_d;
			ph_q    <= ph_d;
			pend_q  <= pend_d;
			init_q  <= init_d;
			wv_s1   <= (state_q == ST_SWEEP);
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		pend_ch_q <= pend_ch_d;
		waddr_s1  <= idx_q;
		wblank_s1 <= !copy_phase;
		if (emit) begin
			cell_q <= emit_cell;
			ocol_q <= 7'(col_d);
			orow_q <= 5'(row_d);
			scr_q  <= emit_scr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign init_busy  = init_q;
	assign done       = done_q;
	assign cell_value = cell_q;
	assign cursor_col = ocol_q;
	assign cursor_row = orow_q;
	assign scrolled   = scr_q;

endmodule

### sv/text_console_char_writer_top.sv
// Text console character writer. Keeps a ROWS x COLUMNS store of 16-bit cells
// (attribute byte high, character byte low) and a cursor. A command is taken
// on a clock edge with start high and busy low; every command gives exactly
// one result beat: done is high for one cycle with cell_value, cursor_col,
// cursor_row and scrolled, and the receiver has no way to hold it off, so it
// must take every done beat. A two-entry command queue sits between the
// classifier and the executing back end, so start is taken while the back
// end is still working, as long as the queue has space. In the back end, a
// read goes through a registered memory read, and a clear or any line break
// on the last row walks the whole cell memory one cell per cycle through its
// single write port (a scroll copies each row one up, reading one row ahead
// of the write). With an idle back end and empty queue, a put, tab or newline
// with no scroll, an unused action or an out-of-range read passes the queue
// count register and then the done register; an in-range read also passes
// the READ state for its memory read. After reset the block runs a clearing
// pass over the cell memory, which holds busy high while it runs; the color
// register can be written during that pass. The color register should only
// be written while no command is in flight; cfg_ready is always high.
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back

module text_console_char_writer_top #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic        clk,
	input  logic        arst_n,
	// command beat
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	// color register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// result beat
	output logic        done,
	output logic [15:0] cell_value,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic        scrolled
);
	import tcw_pkg::*;

	logic       push;
	logic       pop;
	logic       q_full;
	logic       init_busy;
	cmd_t       cmd;
	head_t      head;
	logic [7:0] text_color_q;

	// attribute for new cells and for cells blanked by a clear or scroll
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// classify the command beat and gate it with queue space and the reset clearing pass
	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.start     (start),
		.action    (action),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.q_full    (q_full),
		.init_busy (init_busy),
		.busy      (busy),
		.push      (push),
		.cmd       (cmd)
	);

	// decouples command intake from execution
	tcw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd    (cmd),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	// cursor, cell memory, clear and scroll sweeps, result register
	tcw_back #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.text_color (text_color_q),
		.pop        (pop),
		.init_busy  (init_busy),
		.done       (done),
		.cell_value (cell_value),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.scrolled   (scrolled)
	);

endmodule

### sv/tcw_checker.sv
// port-level checks on the result beats of the text console character writer
// depends on tcw_pkg and text_console_char_writer_top_macros.svh; bound to the top level

`include "text_console_char_writer_top_macros.svh"

module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic [15:0] cell_value,
	input logic [6:0]  cursor_col,
	input logic [4:0]  cursor_row,
	input logic        scrolled
);

	// cursor row never runs past the last row
	`TCW_ASSERT_IMPL(a_row_range, done, int'(cursor_row) <= ROWS - 1, "cursor row out of range")

	// column at most the pending-wrap value
	`TCW_ASSERT_IMPL(a_col_range, done, (COLUMNS >= 128) || (int'(cursor_col) <= COLUMNS), "cursor column out of range")

	// a scroll leaves the cursor at the start of the bottom row, or just past a put
	`TCW_ASSERT_IMPL(a_scroll_pos, done && scrolled, (int'(cursor_row) == ((ROWS - 1) % 32)) && (cursor_col <= 7'd1), "scroll left cursor misplaced")

	// only reads return cell data, and reads never scroll
	`TCW_ASSERT_NEVER(a_scroll_no_cell, done && scrolled && (cell_value != 16'h0000), "scroll beat carries cell data")

endmodule

bind text_console_char_writer_top tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.done       (done),
	.cell_value (cell_value),
	.cursor_col (cursor_col),
	.cursor_row (cursor_row),
	.scrolled   (scrolled)
);

### verif/text_console_char_writer_top_tb.sv
// self-checking testbench for text_console_char_writer_top
// predicts every result beat with a screen tracker class and compares field by field
// depends on tcw_pkg and text_console_char_writer_top
`timescale 1ns / 100ps

module text_console_char_writer_top_tb;

	import tcw_pkg::*;

	localparam int COLUMNS  = DEF_COLUMNS;
	localparam int ROWS     = DEF_ROWS;
	localparam int TAB_STOP = DEF_TAB_STOP;
	localparam int CELLS    = ROWS * COLUMNS;

	// heavy commands (clear, line break on the last row) walk the whole memory
	localparam int WALK_BUDGET  = 120;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 170;

	// one expected result beat
	typedef struct {
		logic [15:0] cell_val;
		logic [6:0]  col;
		logic [4:0]  row;
		logic        scrolled;
	} console_beat_t;

	// shadow of the screen and cursor, plus the beats still to come
	class screen_tracker;
		logic [15:0]   cells [CELLS];
		int unsigned   cur_col;
		int unsigned   cur_row;
		logic [7:0]    color;
		console_beat_t awaited [$];
		int unsigned   errors;

		function new();
			color   = RESET_COLOR;
			cur_col = 0;
			cur_row = 0;
			errors  = 0;
			blank_all();
		endfunction

		function void set_color(logic [7:0] c);
			color = c;
		endfunction

		function void blank_all();
			for (int i = 0; i < CELLS; i++)
				cells[i] = {color, BLANK_CHAR};
		endfunction

		// column to 0; scroll on the last row, else next row
		function bit line_break();
			cur_col = 0;
			if (cur_row + 1 >= ROWS) begin
				cur_row = ROWS - 1;
				for (int i = 0; i + COLUMNS < CELLS; i++)
					cells[i] = cells[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					cells[i] = {color, BLANK_CHAR};
				return 1'b1;
			end
			cur_row++;
			return 1'b0;
		endfunction

		// true when the command makes the block walk its whole memory
		function bit takes_walk(action_t act, logic [7:0] ch);
			int unsigned stop;
			if (act == ACT_CLEAR)
				return 1'b1;
			if (act != ACT_PUT || cur_row != ROWS - 1)
				return 1'b0;
			stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
			if (ch == NEWLINE_CHAR)
				return 1'b1;
			if (ch == TAB_CHAR)
				return stop >= COLUMNS;
			return cur_col >= COLUMNS;
		endfunction

		function void note_command(action_t act, logic [7:0] ch,
				logic [4:0] rr, logic [6:0] rc);
			console_beat_t b;
			int unsigned   stop;
			b.cell_val = '0;
			b.scrolled = 1'b0;
			case (act)
				ACT_PUT: begin
					if (ch == TAB_CHAR) begin
						stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
						if (stop >= COLUMNS)
							b.scrolled = line_break();
						else
							cur_col = stop;
					end else if (ch == NEWLINE_CHAR) begin
						b.scrolled = line_break();
					end else begin
						// a pending wrap takes the line break first
						if (cur_col >= COLUMNS)
							b.scrolled = line_break();
						cells[cur_row * COLUMNS + cur_col] = {color, ch};
						cur_col++;
					end
				end
				ACT_CLEAR: begin
					blank_all();
					cur_col = 0;
					cur_row = 0;
				end
				ACT_READ: begin
					if (rr < ROWS && rc < COLUMNS)
						b.cell_val = cells[rr * COLUMNS + rc];
				end
				default: begin
				end
			endcase
			b.col = cur_col[6:0];
			b.row = cur_row[4:0];
			awaited.push_back(b);
		endfunction

		function void check_beat(logic [15:0] cv, logic [6:0] cc, logic [4:0] cr, logic sc);
			console_beat_t b;
			if (awaited.size() == 0) begin
				$error("result beat with no command waiting");
				errors++;
				return;
			end
			b = awaited.pop_front();
			if (cv !== b.cell_val) begin
				$error("cell_value expected %h actual %h", b.cell_val, cv);
				errors++;
			end
			if (cc !== b.col) begin
				$error("cursor_col expected %0d actual %0d", b.col, cc);
				errors++;
			end
			if (cr !== b.row) begin
				$error("cursor_row expected %0d actual %0d", b.row, cr);
				errors++;
			end
			if (sc !== b.scrolled) begin
				$error("scrolled expected %0b actual %0b", b.scrolled, sc);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [7:0]  char_code;
	logic [4:0]  read_row;
	logic [6:0]  read_col;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        done;
	logic [15:0] cell_value;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic        scrolled;

	screen_tracker tracker;
	int unsigned   walks_used;
	int unsigned   items_done;
	bit            idle_on;

	text_console_char_writer_top #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.done       (done),
		.cell_value (cell_value),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.scrolled   (scrolled)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// every done beat must be taken, so the monitor just checks each one
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_beat(cell_value, cursor_col, cursor_row, scrolled);
	end

	// drive one command beat and hold it until the edge that takes it
	task automatic send_command(action_t act, logic [7:0] ch,
			logic [4:0] rr, logic [6:0] rc);
		start     <= 1'b1;
		action    <= act;
		char_code <= ch;
		read_row  <= rr;
		read_col  <= rc;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_command(act, ch, rr, rc);
	endtask

	task automatic pause_sender(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wrapper for all commands: keeps memory walks within budget, adds sender gaps
	task automatic issue(action_t act, logic [7:0] ch,
			logic [4:0] rr, logic [6:0] rc);
		action_t a;
		a = act;
		if (tracker.takes_walk(a, ch)) begin
			// out of budget, a read stands in for the slow command
			if (walks_used >= WALK_BUDGET)
				a = ACT_READ;
			else
				walks_used++;
		end
		send_command(a, ch, rr, rc);
		if (a != ACT_NONE)
			items_done++;
		if (idle_on && $urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 18));
	endtask

	// block is idle once no beat is awaited and busy is low
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_color(logic [7:0] c);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		tracker.set_color(c);
		cfg_valid <= 1'b0;
	endtask

	// mostly text, some tabs and newlines
	function automatic logic [7:0] text_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return NEWLINE_CHAR;
		if (r < 9)
			return TAB_CHAR;
		return 8'($urandom_range(0, 255));
	endfunction

	// read targets cluster around the cursor so written cells get read back
	task automatic read_near_cursor();
		int unsigned m;
		int unsigned rr;
		int unsigned rc;
		m = $urandom_range(0, 9);
		if (m < 4)
			rr = tracker.cur_row;
		else if (m < 6)
			rr = (tracker.cur_row > 0) ? tracker.cur_row - 1 : 0;
		else if (m < 9)
			rr = $urandom_range(0, ROWS - 1);
		else
			rr = $urandom_range(ROWS, 31);
		m = $urandom_range(0, 9);
		if (m < 5)
			rc = $urandom_range(0, COLUMNS - 1);
		else if (m < 8)
			rc = (tracker.cur_col > 8) ? tracker.cur_col - $urandom_range(1, 8) : 0;
		else
			rc = $urandom_range(COLUMNS, 127);
		issue(ACT_READ, 8'($urandom_range(0, 255)), 5'(rr), 7'(rc));
	endtask

	task automatic random_burst();
		int unsigned kind;
		int unsigned len;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			// run of text, long enough at times to fill a row and wrap
			len = $urandom_range(1, 90);
			repeat (len)
				issue(ACT_PUT, text_char(), 5'($urandom_range(0, 31)),
					7'($urandom_range(0, 127)));
		end else if (kind < 80) begin
			len = $urandom_range(1, 12);
			repeat (len)
				read_near_cursor();
		end else if (kind < 95) begin
			// noise: any action, any field values
			len = $urandom_range(1, 4);
			repeat (len)
				issue(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
		end else begin
			issue(ACT_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				7'($urandom_range(0, 127)));
		end
	endtask

	// run limit, far beyond the slowest correct run
	initial begin
		#200_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		tracker    = new();
		walks_used = 0;
		items_done = 0;
		idle_on    = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		action    <= ACT_NONE;
		char_code <= '0;
		read_row  <= '0;
		read_col  <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset color; first beat waits out the clearing pass
		issue(ACT_PUT, 8'h41, 5'd0, 7'd0);
		issue(ACT_PUT, 8'h00, 5'd31, 7'd127);
		issue(ACT_PUT, 8'hFF, 5'd0, 7'd0);
		issue(ACT_READ, 8'h00, 5'd0, 7'd0);
		issue(ACT_READ, 8'hFF, 5'd0, 7'd2);
		// out-of-range reads give zero
		issue(ACT_READ, 8'h00, 5'd31, 7'd127);
		issue(ACT_READ, 8'h00, 5'd0, 7'd80);
		issue(ACT_READ, 8'h00, 5'd25, 7'd0);
		// untouched corner still blank
		issue(ACT_READ, 8'h00, 5'd24, 7'd79);
		// unused action changes nothing
		issue(ACT_NONE, 8'hFF, 5'd31, 7'd127);
		// tab stops up to the last one, then a tab past it breaks the line
		repeat (10)
			issue(ACT_PUT, TAB_CHAR, 5'd0, 7'd0);
		issue(ACT_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
		issue(ACT_PUT, BLANK_CHAR, 5'd0, 7'd0);
		issue(ACT_READ, 8'h00, 5'd2, 7'd0);
		issue(ACT_CLEAR, 8'h00, 5'd0, 7'd0);
		issue(ACT_READ, 8'h00, 5'd0, 7'd0);

		// random part, one color setting per phase, extremes first
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_color(8'hFF);
				1: write_color(8'h00);
				2: write_color(8'h0F);
				3: write_color(8'hF0);
				default: write_color(8'($urandom_range(0, 255)));
			endcase
			items_done = 0;
			while (items_done < PHASE_ITEMS) begin
				// last phase runs with no gaps at all
				idle_on = (phase != PHASES - 1) && ($urandom_range(0, 9) < 7);
				random_burst();
			end
		end

		drain();
		// tail covers one full memory walk in case of a stray beat
		repeat (CELLS + 16) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
			$display("SUCCESS");
		end else begin
			if (tracker.awaited.size() != 0)
				$error("%0d result beats never arrived", tracker.awaited.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
